### hw/rtl/bmf_pkg.sv
package bmf_pkg;

   // sample and result field widths
   localparam int SAMPLE_W = 8;
   localparam int PIXEL_W  = 3 * SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 8'd255;

   // kernel register is 5 bits, so the window never exceeds 31 x 31 samples
   localparam int KSIZE_W = 5;
   localparam int HALF_W  = KSIZE_W - 1;
   localparam int DIVS_W  = 2 * KSIZE_W;
   localparam int SUM_W   = 18;
   localparam int DCNT_W  = 5;

   // register file
   localparam int WIDTH_W = 12;
   localparam int HGT_W   = 13;
   localparam int CHAN_W  = 3;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_KERNEL_SIZE   = 2'd2;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd3;

   localparam logic [CHAN_W-1:0] CH_GRAY_ALPHA = 3'd2;
   localparam logic [CHAN_W-1:0] CH_RGB        = 3'd3;
   localparam logic [CHAN_W-1:0] CH_RGBA       = 3'd4;

   localparam logic [0:0] ACT_PIXEL = 1'b0;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ,
      S_WAIT,
      S_DIV,
      S_OUT
   } state_type;

endpackage

### hw/rtl/bmf_if.sv
interface bmf_req_if;
   logic                            valid;
   logic                            ready;
   logic                            action;
   logic [bmf_pkg::SAMPLE_W-1:0]    sample_a;
   logic [bmf_pkg::SAMPLE_W-1:0]    sample_b;
   logic [bmf_pkg::SAMPLE_W-1:0]    sample_c;

   modport source (output valid, action, sample_a, sample_b, sample_c, input ready);
   modport sink (input valid, action, sample_a, sample_b, sample_c, output ready);
endinterface

interface bmf_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bmf_pkg::SAMPLE_W-1:0]    mean_a;
   logic [bmf_pkg::SAMPLE_W-1:0]    mean_b;
   logic [bmf_pkg::SAMPLE_W-1:0]    mean_c;
   logic [bmf_pkg::SAMPLE_W-1:0]    alpha_out;
   logic                            last_in_frame;

   modport source (output valid, mean_a, mean_b, mean_c, alpha_out, last_in_frame,
                   input ready);
   modport sink (input valid, mean_a, mean_b, mean_c, alpha_out, last_in_frame,
                 output ready);
endinterface

### hw/rtl/box_mean_filter_2d_unit.sv
// box mean filter over a raster pixel stream
// req_if carries one word per pixel (action 0) or a flush tick (action 1);
// rsp_if returns at most one mean word per accepted request word, in raster
// order, the tail of a frame being drained with flush ticks
// registers sit on an apb-style port at byte addresses 0, 4, 8, 12:
// image width, image height, kernel size, channel count; any write restarts
// the frame counters and drops pending outputs, the line store is kept
// flow: one request word is in flight at a time; a word that releases a
// result reads its in-image window samples (up to 961 for a 31x31 kernel)
// through the single read port of the line store, one window sample per
// cycle, then the restoring divider divides the three sums by k squared;
// a word with no result returns to idle straight from the check state
// reset returns the registers to 640 x 480, kernel 19, one channel, and
// clears the frame position counters; the line store itself is not cleared
// a stalled receiver holds the result register; the next word is still
// accepted and worked on, and waits only if its result is ready before the
// previous one has been taken
module box_mean_filter_2d_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_KERNEL = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   bmf_req_if.sink                      req_if,
   bmf_rsp_if.source                    rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bmf_pkg::ADDR_W-1:0]   paddr,
   input  logic [bmf_pkg::DATA_W-1:0]   pwdata,
   output logic [bmf_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RING  = MAX_KERNEL + 1;
   localparam int RGW   = $clog2(RING);
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = bmf_pkg::HGT_W;
   localparam int SW    = bmf_pkg::SUM_W;
   localparam int DW    = bmf_pkg::DIVS_W;
   localparam int HW    = bmf_pkg::HALF_W;
   localparam int KW    = bmf_pkg::KSIZE_W;

   // ---------------- configuration registers ----------------
   logic [bmf_pkg::WIDTH_W-1:0]  width_ff;
   logic [bmf_pkg::HGT_W-1:0]    height_ff;
   logic [KW-1:0]                ksize_ff;
   logic [bmf_pkg::CHAN_W-1:0]   chan_ff;
   logic                         csr_wr;
   logic [1:0]                   csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         ksize_ff  <= 5'd19;
         chan_ff   <= 3'd1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            bmf_pkg::REG_IMAGE_WIDTH:   width_ff  <= pwdata[bmf_pkg::WIDTH_W-1:0];
            bmf_pkg::REG_IMAGE_HEIGHT:  height_ff <= pwdata[bmf_pkg::HGT_W-1:0];
            bmf_pkg::REG_KERNEL_SIZE:   ksize_ff  <= pwdata[KW-1:0];
            bmf_pkg::REG_CHANNEL_COUNT: chan_ff   <= pwdata[bmf_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         bmf_pkg::REG_IMAGE_WIDTH:   prdata = 32'(width_ff);
         bmf_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(height_ff);
         bmf_pkg::REG_KERNEL_SIZE:   prdata = 32'(ksize_ff);
         bmf_pkg::REG_CHANNEL_COUNT: prdata = 32'(chan_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------- effective geometry ----------------
   logic [CW:0]   w_eff;
   logic [CW-1:0] w_m1;
   logic [RW-1:0] h_m1;
   logic [KW-1:0] k_eff;
   logic [HW-1:0] half;

   always_comb begin
      if (width_ff == '0)
         w_eff = (CW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH)
         w_eff = (CW+1)'(MAX_WIDTH);
      else
         w_eff = (CW+1)'(width_ff);
      w_m1 = CW'(w_eff - (CW+1)'(1));
      h_m1 = (height_ff == '0) ? '0 : height_ff - RW'(1);
      if (ksize_ff == '0)
         k_eff = KW'(1);
      else if (32'(ksize_ff) > MAX_KERNEL)
         k_eff = KW'(MAX_KERNEL);
      else
         k_eff = ksize_ff;
      half = HW'((k_eff - KW'(1)) >> 1);
   end

   // ---------------- stream position state ----------------
   bmf_pkg::state_type state_ff, state_in;
   logic [RW-1:0]  in_row_ff, out_row_ff;
   logic [CW-1:0]  in_col_ff, out_col_ff;
   logic [RGW-1:0] in_ring_ff, out_ring_ff;
   logic           frame_in_ff;

   // window walk
   logic [RW-1:0]  y_ff, y1_ff;
   logic [CW-1:0]  x_ff, x0_ff, x1_ff;
   logic [RGW-1:0] ring_ff;
   logic           rd_vld_ff;
   logic [bmf_pkg::PIXEL_W-1:0] rd_data_ff;

   // sums, then quotients after the divide
   logic [SW-1:0]       sum_ff [3];
   logic [DW-1:0]       rem_ff [3];
   logic [DW-1:0]       div_ff;
   logic [bmf_pkg::DCNT_W-1:0] div_cnt_ff;

   // result register
   logic                        rsp_valid_ff;
   logic [bmf_pkg::SAMPLE_W-1:0] mean_a_ff, mean_b_ff, mean_c_ff, alpha_ff;
   logic                        last_ff;

   logic accept, do_write, out_load, win_ready, last_issue;

   assign accept     = req_if.valid & req_if.ready;
   assign do_write   = accept & (req_if.action == bmf_pkg::ACT_PIXEL) & ~frame_in_ff;
   assign out_load   = (state_ff == bmf_pkg::S_OUT) & (~rsp_valid_ff | rsp_if.ready);
   assign last_issue = (y_ff == y1_ff) & (x_ff == x1_ff);

   // window clipping for the next output pixel
   logic [RW:0]    row_hi;
   logic [CW:0]    col_hi;
   logic [RW-1:0]  need_row, y0, y1;
   logic [CW-1:0]  need_col, x0, x1;
   logic [HW-1:0]  up_rows;
   logic [RGW:0]   ring_sum;
   logic [RGW-1:0] ring0;

   always_comb begin
      row_hi   = (RW+1)'(out_row_ff) + (RW+1)'(half);
      col_hi   = (CW+1)'(out_col_ff) + (CW+1)'(half);
      need_row = (row_hi > (RW+1)'(h_m1)) ? h_m1 : RW'(row_hi);
      need_col = (col_hi > (CW+1)'(w_m1)) ? w_m1 : CW'(col_hi);
      y1       = need_row;
      x1       = need_col;
      y0       = (out_row_ff >= RW'(half)) ? out_row_ff - RW'(half) : '0;
      x0       = (out_col_ff >= CW'(half)) ? out_col_ff - CW'(half) : '0;
      // rows above the output row that lie inside the image
      up_rows  = (out_row_ff >= RW'(half)) ? half : HW'(out_row_ff);
      if ((RGW+1)'(out_ring_ff) >= (RGW+1)'(up_rows))
         ring_sum = (RGW+1)'(out_ring_ff) - (RGW+1)'(up_rows);
      else
         ring_sum = (RGW+1)'(out_ring_ff) + (RGW+1)'(RING) - (RGW+1)'(up_rows);
      ring0 = RGW'(ring_sum);
      // has every sample of the window arrived
      win_ready = frame_in_ff | (in_row_ff > need_row) |
                  ((in_row_ff == need_row) & (in_col_ff > need_col));
   end

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmf_pkg::S_IDLE:  if (accept) state_in = bmf_pkg::S_CHECK;
         bmf_pkg::S_CHECK: state_in = win_ready ? bmf_pkg::S_READ : bmf_pkg::S_IDLE;
         bmf_pkg::S_READ:  if (last_issue) state_in = bmf_pkg::S_WAIT;
         bmf_pkg::S_WAIT:  state_in = bmf_pkg::S_DIV;
         bmf_pkg::S_DIV:
            if (div_cnt_ff == bmf_pkg::DCNT_W'(SW-1)) state_in = bmf_pkg::S_OUT;
         bmf_pkg::S_OUT:   if (out_load) state_in = bmf_pkg::S_IDLE;
         default:          state_in = bmf_pkg::S_IDLE;
      endcase
      if (csr_wr) state_in = bmf_pkg::S_IDLE;
   end

   always_comb begin
      unique case (state_ff)
         bmf_pkg::S_IDLE: req_if.ready = 1'b1;
         default:         req_if.ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bmf_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- line store ----------------
   logic [bmf_pkg::PIXEL_W-1:0] line_mem [DEPTH];
   logic [AW-1:0] wr_addr, rd_addr;

   assign wr_addr = AW'(in_ring_ff) * AW'(MAX_WIDTH) + AW'(in_col_ff);
   assign rd_addr = AW'(ring_ff) * AW'(MAX_WIDTH) + AW'(x_ff);

   always_ff @(posedge clock) begin
      if (do_write)
         line_mem[wr_addr] <= {req_if.sample_c, req_if.sample_b, req_if.sample_a};
      if (state_ff == bmf_pkg::S_READ)
         rd_data_ff <= line_mem[rd_addr];
   end

   // ---------------- input position ----------------
   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         in_ring_ff  <= '0;
         frame_in_ff <= 1'b0;
      end else begin
         if (do_write) begin
            if (in_col_ff == w_m1) begin
               in_col_ff <= '0;
               if (in_row_ff == h_m1) begin
                  in_row_ff   <= '0;
                  in_ring_ff  <= '0;
                  frame_in_ff <= 1'b1;
               end else begin
                  in_row_ff  <= in_row_ff + RW'(1);
                  in_ring_ff <= (in_ring_ff == RGW'(RING-1)) ? '0 : in_ring_ff + RGW'(1);
               end
            end else begin
               in_col_ff <= in_col_ff + CW'(1);
            end
         end
         // the last output of a frame reopens the input side
         if (out_load && out_col_ff == w_m1 && out_row_ff == h_m1)
            frame_in_ff <= 1'b0;
      end
   end

   // ---------------- output position ----------------
   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         out_ring_ff <= '0;
      end else if (out_load) begin
         if (out_col_ff == w_m1) begin
            out_col_ff <= '0;
            if (out_row_ff == h_m1) begin
               out_row_ff  <= '0;
               out_ring_ff <= '0;
            end else begin
               out_row_ff  <= out_row_ff + RW'(1);
               out_ring_ff <= (out_ring_ff == RGW'(RING-1)) ? '0 : out_ring_ff + RGW'(1);
            end
         end else begin
            out_col_ff <= out_col_ff + CW'(1);
         end
      end
   end

   // ---------------- window walk, accumulate and divide ----------------
   logic [DW:0]   trial [3];
   logic          fits  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i] = {rem_ff[i], sum_ff[i][SW-1]};
         fits[i]  = trial[i] >= (DW+1)'(div_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= (state_ff == bmf_pkg::S_READ);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bmf_pkg::S_CHECK: begin
            y_ff    <= y0;
            y1_ff   <= y1;
            x_ff    <= x0;
            x0_ff   <= x0;
            x1_ff   <= x1;
            ring_ff <= ring0;
            div_ff  <= DW'(k_eff) * DW'(k_eff);
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         end
         bmf_pkg::S_READ: begin
            if (x_ff == x1_ff) begin
               x_ff    <= x0_ff;
               y_ff    <= y_ff + RW'(1);
               ring_ff <= (ring_ff == RGW'(RING-1)) ? '0 : ring_ff + RGW'(1);
            end else begin
               x_ff <= x_ff + CW'(1);
            end
         end
         bmf_pkg::S_DIV: begin
            div_cnt_ff <= div_cnt_ff + bmf_pkg::DCNT_W'(1);
            for (int i = 0; i < 3; i++) begin
               if (fits[i]) begin
                  rem_ff[i] <= DW'(trial[i] - (DW+1)'(div_ff));
                  sum_ff[i] <= {sum_ff[i][SW-2:0], 1'b1};
               end else begin
                  rem_ff[i] <= DW'(trial[i]);
                  sum_ff[i] <= {sum_ff[i][SW-2:0], 1'b0};
               end
            end
         end
         default: ;
      endcase
      // last read word lands during the wait state
      if (rd_vld_ff) begin
         for (int i = 0; i < 3; i++)
            sum_ff[i] <= sum_ff[i] + SW'(rd_data_ff[i*bmf_pkg::SAMPLE_W +: bmf_pkg::SAMPLE_W]);
      end
      if (state_ff == bmf_pkg::S_WAIT) begin
         div_cnt_ff <= '0;
         for (int i = 0; i < 3; i++) rem_ff[i] <= '0;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         mean_a_ff <= sum_ff[0][bmf_pkg::SAMPLE_W-1:0];
         if (chan_ff == bmf_pkg::CH_RGB) begin
            mean_b_ff <= sum_ff[1][bmf_pkg::SAMPLE_W-1:0];
            mean_c_ff <= sum_ff[2][bmf_pkg::SAMPLE_W-1:0];
         end else begin
            mean_b_ff <= (chan_ff == bmf_pkg::CH_GRAY_ALPHA) ? bmf_pkg::SAMPLE_MAX : '0;
            mean_c_ff <= '0;
         end
         alpha_ff <= (chan_ff == bmf_pkg::CH_GRAY_ALPHA || chan_ff == bmf_pkg::CH_RGBA) ?
                     bmf_pkg::SAMPLE_MAX : '0;
         last_ff  <= (out_row_ff == h_m1) && (out_col_ff == w_m1);
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.mean_a        = mean_a_ff;
   assign rsp_if.mean_b        = mean_b_ff;
   assign rsp_if.mean_c        = mean_c_ff;
   assign rsp_if.alpha_out     = alpha_ff;
   assign rsp_if.last_in_frame = last_ff;

`ifndef SYNTHESIS
   a_frame_in_pos: assert property (@(posedge clock) disable iff (reset)
      frame_in_ff |-> (in_row_ff == '0 && in_col_ff == '0))
      else $error("input position not at origin while frame is complete");

   a_walk_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmf_pkg::S_READ) |-> (y_ff <= y1_ff && x_ff <= x1_ff))
      else $error("window walk ran past its last sample");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bmf_pkg::S_DIV) |-> (div_cnt_ff < bmf_pkg::DCNT_W'(SW)))
      else $error("divider ran too many steps");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (out_load && !csr_wr) |=> rsp_valid_ff)
      else $error("result lost after load");
`endif

endmodule

### tb/box_mean_filter_2d_unit_tb.sv
module box_mean_filter_2d_unit_tb;

   localparam int RING_ROWS   = 32;
   localparam int STORE_W     = 2048;
   localparam int SETTLE_CYC  = 1100;   // long enough for a full 31 x 31 window to finish
   localparam int WATCHDOG    = 60000;  // cycles with no accepted word, taken mean or register access at all
   localparam logic [0:0] ACT_FLUSH = 1'b1;

   typedef struct packed {
      logic [0:0]                   action;
      logic [bmf_pkg::SAMPLE_W-1:0] a;
      logic [bmf_pkg::SAMPLE_W-1:0] b;
      logic [bmf_pkg::SAMPLE_W-1:0] c;
   } pixel_word_type;

   typedef struct packed {
      logic [bmf_pkg::SAMPLE_W-1:0] mean_a;
      logic [bmf_pkg::SAMPLE_W-1:0] mean_b;
      logic [bmf_pkg::SAMPLE_W-1:0] mean_c;
      logic [bmf_pkg::SAMPLE_W-1:0] alpha;
      logic                         last;
   } mean_word_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [bmf_pkg::ADDR_W-1:0] paddr;
   logic [bmf_pkg::DATA_W-1:0] pwdata;
   logic [bmf_pkg::DATA_W-1:0] prdata;
   logic pready;

   bmf_req_if req_bus ();
   bmf_rsp_if rsp_bus ();

   box_mean_filter_2d_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_bus),
      .rsp_if  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // pixel words waiting for the driver, means waiting for the monitor
   pixel_word_type pixel_q[$];
   mean_word_type  mean_q[$];

   // shadow of the filter: registers, counters and the line store
   logic [bmf_pkg::WIDTH_W-1:0]  reg_width;
   logic [bmf_pkg::HGT_W-1:0]    reg_height;
   logic [bmf_pkg::KSIZE_W-1:0]  reg_ksize;
   logic [bmf_pkg::CHAN_W-1:0]   reg_chan;
   logic [bmf_pkg::PIXEL_W-1:0]  line_mem [0:RING_ROWS*STORE_W-1];
   int unsigned in_row, in_col, out_row, out_col;
   bit          frame_done;

   int  mismatches;
   int  words_sent;
   int  idle_cycles;
   bit  calm;
   bit  req_taken;
   pixel_word_type next_word;

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void restart_frame();
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      frame_done = 0;
   endfunction

   // advance the shadow by one word and queue the mean it releases, if any
   function automatic void predict_mean(pixel_word_type pw);
      int unsigned w, hgt, k, h, dv, nr, nc, sa, sb, sc;
      longint unsigned need, have;
      bit ready;
      int y, x;
      logic [bmf_pkg::PIXEL_W-1:0] v;
      mean_word_type m;
      w   = (reg_width == 0) ? 1 : (reg_width > STORE_W ? STORE_W : reg_width);
      hgt = (reg_height == 0) ? 1 : reg_height;
      k   = (reg_ksize == 0) ? 1 : reg_ksize;
      h   = (k - 1) / 2;
      dv  = k * k;
      // pixels arriving after the frame is in are dropped and count as a flush
      if (pw.action == bmf_pkg::ACT_PIXEL && !frame_done) begin
         line_mem[(in_row % RING_ROWS) * STORE_W + in_col] = {pw.c, pw.b, pw.a};
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
            if (in_row >= hgt) begin
               in_row = 0;
               frame_done = 1;
            end
         end
      end
      if (frame_done) begin
         ready = 1;
      end else begin
         // bottom-right window sample, clipped to the image, must have arrived
         nr = out_row + h;
         nc = out_col + h;
         if (nr > hgt - 1) nr = hgt - 1;
         if (nc > w - 1) nc = w - 1;
         need  = longint'(nr) * w + nc;
         have  = longint'(in_row) * w + in_col;
         ready = have > need;
      end
      if (!ready) return;
      sa = 0; sb = 0; sc = 0;
      for (y = int'(out_row) - int'(h); y <= int'(out_row) + int'(h); y++) begin
         if (y < 0 || y >= int'(hgt)) continue;
         for (x = int'(out_col) - int'(h); x <= int'(out_col) + int'(h); x++) begin
            if (x < 0 || x >= int'(w)) continue;
            v = line_mem[(y % RING_ROWS) * STORE_W + x];
            sa += v[7:0];
            sb += v[15:8];
            sc += v[23:16];
         end
      end
      m.mean_a = 8'((sa / dv) & 255);
      m.mean_b = (reg_chan == bmf_pkg::CH_RGB) ? 8'((sb / dv) & 255) :
                 (reg_chan == bmf_pkg::CH_GRAY_ALPHA ? bmf_pkg::SAMPLE_MAX : 8'd0);
      m.mean_c = (reg_chan == bmf_pkg::CH_RGB) ? 8'((sc / dv) & 255) : 8'd0;
      m.alpha  = (reg_chan == bmf_pkg::CH_GRAY_ALPHA || reg_chan == bmf_pkg::CH_RGBA) ?
                 bmf_pkg::SAMPLE_MAX : 8'd0;
      m.last   = (out_row == hgt - 1 && out_col == w - 1);
      mean_q.push_back(m);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
         if (out_row >= hgt) begin
            out_row = 0;
            frame_done = 0;
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus
   task automatic send_word(logic [0:0] act, logic [7:0] a, logic [7:0] b, logic [7:0] c);
      pixel_word_type pw;
      pw.action = act; pw.a = a; pw.b = b; pw.c = c;
      predict_mean(pw);
      pixel_q.push_back(pw);
      words_sent++;
   endtask

   task automatic send_rand_pixel();
      send_word(bmf_pkg::ACT_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // hold off until the block has nothing left to do
   task automatic wait_drained();
      while (pixel_q.size() != 0 || mean_q.size() != 0 || req_bus.valid)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle, registered on the access edge
   task automatic write_reg(logic [1:0] idx, logic [bmf_pkg::DATA_W-1:0] val);
      wait_drained();
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= bmf_pkg::ADDR_W'({idx, 2'b00}); pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         bmf_pkg::REG_IMAGE_WIDTH:   reg_width  = val[bmf_pkg::WIDTH_W-1:0];
         bmf_pkg::REG_IMAGE_HEIGHT:  reg_height = val[bmf_pkg::HGT_W-1:0];
         bmf_pkg::REG_KERNEL_SIZE:   reg_ksize  = val[bmf_pkg::KSIZE_W-1:0];
         bmf_pkg::REG_CHANNEL_COUNT: reg_chan   = val[bmf_pkg::CHAN_W-1:0];
         default: ;
      endcase
      restart_frame();
   endtask

   task automatic set_shape(int w, int hg, int k, int ch);
      write_reg(bmf_pkg::REG_IMAGE_WIDTH, w);
      write_reg(bmf_pkg::REG_IMAGE_HEIGHT, hg);
      write_reg(bmf_pkg::REG_KERNEL_SIZE, k);
      write_reg(bmf_pkg::REG_CHANNEL_COUNT, ch);
   endtask

   // one whole frame with random content and stray flushes, then drained;
   // while draining a pixel now and then stands in for a flush
   task automatic run_frame(int npix);
      int i;
      for (i = 0; i < npix; i++) begin
         if ($urandom_range(9) == 0) send_word(ACT_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
         send_rand_pixel();
      end
      while (frame_done) begin
         if ($urandom_range(4) == 0) send_rand_pixel();
         else send_word(ACT_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
      end
      // flush with nothing ready
      if ($urandom_range(2) == 0) send_word(ACT_FLUSH, 8'hFF, 8'hFF, 8'hFF);
   endtask

   // ---------------------------------------------------------------- driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (!req_bus.valid || req_taken) begin
            if (pixel_q.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
               next_word = pixel_q.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.action   <= next_word.action;
               req_bus.sample_a <= next_word.a;
               req_bus.sample_b <= next_word.b;
               req_bus.sample_c <= next_word.c;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         rsp_bus.ready <= calm || ($urandom_range(99) >= 29);
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      mean_word_type got, want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (psel && penable))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("box_mean_filter_2d_unit test failed");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.mean_a = rsp_bus.mean_a;
            got.mean_b = rsp_bus.mean_b;
            got.mean_c = rsp_bus.mean_c;
            got.alpha  = rsp_bus.alpha_out;
            got.last   = rsp_bus.last_in_frame;
            if (mean_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected mean word %h", got);
            end else begin
               want = mean_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mean mismatch: exp a=%0d b=%0d c=%0d alpha=%0d last=%0d,",
                               " got a=%0d b=%0d c=%0d alpha=%0d last=%0d"},
                              want.mean_a, want.mean_b, want.mean_c, want.alpha, want.last,
                              got.mean_a, got.mean_b, got.mean_c, got.alpha, got.last);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      int i, w, hg;
      clock = 0; reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_bus.valid = 0; req_bus.action = bmf_pkg::ACT_PIXEL;
      req_bus.sample_a = 0; req_bus.sample_b = 0; req_bus.sample_c = 0;
      rsp_bus.ready = 0;
      req_taken = 0; mismatches = 0; words_sent = 0; idle_cycles = 0; calm = 0;
      for (i = 0; i < RING_ROWS * STORE_W; i++) line_mem[i] = '0;
      reg_width = 640; reg_height = 480; reg_ksize = 19; reg_chan = 1;
      restart_frame();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // a few words of extreme samples under the reset shape
      send_word(bmf_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      send_word(bmf_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00);
      send_word(ACT_FLUSH, 8'h00, 8'h00, 8'h00);

      // small rgb frame of all-max samples, then all-zero
      set_shape(3, 3, 3, 3);
      for (i = 0; i < 9; i++) send_word(bmf_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
      while (frame_done) send_word(ACT_FLUSH, 8'h00, 8'h00, 8'h00);
      for (i = 0; i < 9; i++) send_word(bmf_pkg::ACT_PIXEL, 8'h00, 8'h00, 8'h00);
      while (frame_done) send_word(bmf_pkg::ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);

      // zero width and height, zero kernel, gray plus alpha
      set_shape(0, 0, 0, 2);
      run_frame(1);
      // even kernel under rgba, then the largest kernel with channel count 7
      set_shape(4, 2, 2, 4);
      run_frame(8);
      write_reg(bmf_pkg::REG_KERNEL_SIZE, 31);
      write_reg(bmf_pkg::REG_CHANNEL_COUNT, 7);
      run_frame(8);
      // oversize width saturates; frame abandoned by the next write
      set_shape(4095, 1, 1, 0);
      for (i = 0; i < 4; i++) send_rand_pixel();
      set_shape(2048, 8191, 1, 5);
      for (i = 0; i < 4; i++) send_rand_pixel();

      // random frames; the first stretch with no idling on either side
      calm = 1;
      while (words_sent < 430) begin
         if (words_sent > 150) calm = 0;
         w  = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8, 1);
         hg = ($urandom_range(9) == 0) ? $urandom_range(10, 5) : $urandom_range(5, 1);
         set_shape(w, hg, $urandom_range(31), $urandom_range(7));
         if ($urandom_range(5) == 0) begin
            // broken frame, cut short by the next register write
            for (i = 0; i < $urandom_range(w * hg); i++) send_rand_pixel();
         end else begin
            run_frame(w * hg);
         end
      end
      calm = 0;

      wait_drained();
      if (mismatches == 0)
         $display("box_mean_filter_2d_unit test passed");
      else
         $display("box_mean_filter_2d_unit test failed");
      $finish;
   end

endmodule
